// File: hdl/mtfcd_pkg.sv
package mtfcd_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int KEY_W    = 31;
    localparam int SIZE_W   = 19;
    localparam int BYTES_W  = 25;
    localparam int BUDGET_W = 24;
    localparam int OP_W     = 2;
    localparam int POS_W    = 8;
    localparam int EVC_W    = 8;
    localparam int OCC_W    = 9;

    localparam logic [BUDGET_W-1:0] BUDGET_AT_RESET = BUDGET_W'(500000);

    localparam logic [OP_W-1:0] OP_ACCESS    = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] entry_bytes;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [POS_W-1:0]   hit_position;
        logic [EVC_W-1:0]   evicted_count;
        logic [OCC_W-1:0]   occupancy;
        logic [BYTES_W-1:0] total_bytes;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

endpackage

// File: hdl/mtfcd_entry_ram.sv
module mtfcd_entry_ram (
    input  logic                         clk,
    input  mtfcd_pkg::mem_wr_t           wr,
    input  logic [mtfcd_pkg::IDX_W-1:0]  raddr,
    output mtfcd_pkg::entry_t            rdata
);
    import mtfcd_pkg::*;

    entry_t mem [SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/mtfcd_seq.sv
module mtfcd_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  mtfcd_pkg::req_t                 req,
    input  logic [mtfcd_pkg::BUDGET_W-1:0]  budget,
    input  logic                            rsp_free,
    output logic                            rsp_load,
    output mtfcd_pkg::rsp_t                 rsp,
    output mtfcd_pkg::mem_wr_t              mem_wr,
    output logic [mtfcd_pkg::IDX_W-1:0]     mem_raddr,
    input  mtfcd_pkg::entry_t               mem_rdata
);
    import mtfcd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_FRONT = 3'd3;
    localparam logic [2:0] S_EVCHK = 3'd4;
    localparam logic [2:0] S_EVSUB = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]         state_reg,  state_next;
    logic [OP_W-1:0]    op_reg,     op_next;
    logic [KEY_W-1:0]   key_reg,    key_next;
    logic [SIZE_W-1:0]  nbytes_reg, nbytes_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [BYTES_W-1:0] bytes_reg,  bytes_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    entry_t             held_reg,   held_next;
    logic               found_reg,  found_next;
    logic [IDX_W-1:0]   pos_reg,    pos_next;
    logic [SIZE_W-1:0]  size_reg,   size_next;
    logic [EVC_W-1:0]   evc_reg,    evc_next;

    logic               match;
    logic               last;
    logic [BYTES_W:0]   need;
    logic               over;

    assign match = (mem_rdata.key == key_reg);
    assign last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign need  = {1'b0, bytes_reg} + (BYTES_W + 1)'(nbytes_reg);
    assign over  = (bytes_reg != '0) && (need > (BYTES_W + 1)'(budget))
                   && (count_reg > CNT_W'(1));

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        rsp.hit           = found_reg;
        rsp.hit_position  = POS_W'(pos_reg);
        rsp.evicted_count = evc_reg;
        rsp.occupancy     = OCC_W'(count_reg);
        rsp.total_bytes   = bytes_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        nbytes_next = nbytes_reg;
        count_next  = count_reg;
        bytes_next  = bytes_reg;
        idx_next    = idx_reg;
        held_next   = held_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        size_next   = size_reg;
        evc_next    = evc_reg;
        mem_wr      = '0;
        mem_raddr   = IDX_W'(idx_reg + IDX_W'(1));
        rsp_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (req_valid)
                begin
                    op_next     = req.op;
                    key_next    = req.key;
                    nbytes_next = req.entry_bytes;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    evc_next    = '0;
                    idx_next    = '0;
                    case (req.op)
                        OP_ACCESS:
                        begin
                            if (count_reg == '0)
                            begin
                                count_next = CNT_W'(1);
                                state_next = S_FRONT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        OP_CLEAR_ALL:
                        begin
                            count_next = '0;
                            bytes_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (op_reg == OP_ACCESS)
                begin
                    if (idx_reg != '0)
                    begin
                        mem_wr.we   = 1'b1;
                        mem_wr.addr = idx_reg;
                        mem_wr.data = held_reg;
                    end
                    held_next = mem_rdata;
                    if (match)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_reg;
                        size_next  = mem_rdata.size;
                        state_next = S_FRONT;
                    end
                    else if (last)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_reg + IDX_W'(1));
                    end
                end
                else
                begin
                    if (found_reg)
                    begin
                        mem_wr.we   = 1'b1;
                        mem_wr.addr = IDX_W'(idx_reg - IDX_W'(1));
                        mem_wr.data = mem_rdata;
                    end
                    else if (match)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_reg;
                        bytes_next = bytes_reg - BYTES_W'(mem_rdata.size);
                    end
                    if (last)
                    begin
                        if (found_reg || match)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = IDX_W'(idx_reg + IDX_W'(1));
                    end
                end
            end
            S_TAIL:
            begin
                if (count_reg == CNT_W'(SLOTS))
                begin
                    bytes_next = bytes_reg - BYTES_W'(held_reg.size);
                    evc_next   = EVC_W'(1);
                end
                else
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = IDX_W'(count_reg);
                    mem_wr.data = held_reg;
                    count_next  = count_reg + CNT_W'(1);
                end
                state_next = S_FRONT;
            end
            S_FRONT:
            begin
                mem_wr.we       = 1'b1;
                mem_wr.addr     = '0;
                mem_wr.data.key = key_reg;
                mem_wr.data.size = found_reg ? size_reg : nbytes_reg;
                state_next      = found_reg ? S_DONE : S_EVCHK;
            end
            S_EVCHK:
            begin
                mem_raddr = IDX_W'(count_reg - CNT_W'(1));
                if (over)
                begin
                    count_next = count_reg - CNT_W'(1);
                    evc_next   = evc_reg + EVC_W'(1);
                    state_next = S_EVSUB;
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_EVSUB:
            begin
                bytes_next = bytes_reg - BYTES_W'(mem_rdata.size);
                state_next = S_EVCHK;
            end
            S_ADD:
            begin
                bytes_next = bytes_reg + BYTES_W'(nbytes_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        nbytes_reg <= nbytes_next;
        idx_reg    <= idx_next;
        held_reg   <= held_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        size_reg   <= size_next;
        evc_reg    <= evc_next;
    end

endmodule

// File: hdl/mtf_cache_directory_with_byte_budget.sv
// Move-to-front cache directory with a byte budget. Keys and sizes live in a
// single-port-read memory that one sequencer walks an entry per cycle. A clear walks the
// whole directory, an access that hits at position p walks entries 0 to p, and a miss
// walks the whole directory, then evicts tail entries one by one for the budget; clear-all
// or an unused op goes straight to the result. req_ready is high only between
// transactions; once a result is in the output register, the next request can be taken
// while it waits, but the sequencer holds a new result until that register is free.
// The user must write byte_budget through cfg_valid/cfg_data only while the block is
// idle; the block itself does not enforce this.
module mtf_cache_directory_with_byte_budget (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mtfcd_pkg::BUDGET_W-1:0]  cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  mtfcd_pkg::req_t                 req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output mtfcd_pkg::rsp_t                 rsp
);
    import mtfcd_pkg::*;

    logic [BUDGET_W-1:0] budget_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                rsp_free;
    logic                rsp_load;
    rsp_t                rsp_next;
    mem_wr_t             mem_wr;
    logic [IDX_W-1:0]    mem_raddr;
    entry_t              mem_rdata;

    assign cfg_ready = 1'b1;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    mtfcd_entry_ram u_ram (
        .clk   (clk),
        .wr    (mem_wr),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mtfcd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .budget    (budget_reg),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp       (rsp_next),
        .mem_wr    (mem_wr),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= BUDGET_AT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                budget_reg <= cfg_data;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: tb/tb_mtf_cache_directory_with_byte_budget.sv
`timescale 1ns / 1ps

module tb_mtf_cache_directory_with_byte_budget;

    import mtfcd_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned MAX_ENTRY_BYTES = 524280;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned TAIL_CYCLES = 1200;
    localparam int unsigned LONG_HOLD = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [BUDGET_W-1:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    req_t pending_req[$];
    rsp_t expected_rsp[$];

    logic [KEY_W-1:0] dir_key [SLOTS];
    int unsigned dir_size [SLOTS];
    int unsigned dir_count = 0;
    int unsigned dir_bytes = 0;
    int unsigned byte_limit = 32'(BUDGET_AT_RESET);

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_token = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    int unsigned errors = 0;
    int unsigned n_rsp = 0;
    int unsigned n_hits = 0;
    int unsigned n_evicting = 0;
    int unsigned peak_occ = 0;
    int unsigned n_budgets = 0;

    mtf_cache_directory_with_byte_budget dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shift entries [0, pos) down by one, leaving slot 0 free
    function automatic void open_front(int unsigned pos);
        int unsigned i;
        for (i = pos; i > 0; i--)
        begin
            dir_key[i] = dir_key[i - 1];
            dir_size[i] = dir_size[i - 1];
        end
    endfunction

    function automatic rsp_t mtf_lookup(req_t r);
        rsp_t res;
        int unsigned pos;
        int unsigned n_evict;
        int unsigned slot;
        int unsigned sz;
        int unsigned i;
        bit found;
        res = '0;
        pos = 0;
        n_evict = 0;
        found = 1'b0;
        if (r.op == OP_ACCESS)
        begin
            for (i = 0; i < dir_count; i++)
            begin
                if (!found && dir_key[i] == r.key)
                begin
                    found = 1'b1;
                    pos = i;
                end
            end
            if (found)
            begin
                sz = dir_size[pos];
                open_front(pos);
                dir_key[0] = r.key;
                dir_size[0] = sz;
            end
            else
            begin
                if (dir_count == SLOTS)
                begin
                    slot = SLOTS - 1;
                    dir_bytes -= dir_size[slot];
                    n_evict++;
                end
                else
                begin
                    slot = dir_count;
                    dir_count++;
                end
                open_front(slot);
                dir_key[0] = r.key;
                dir_size[0] = 32'(r.entry_bytes);
                while (dir_bytes != 0 && dir_bytes + 32'(r.entry_bytes) > byte_limit
                       && dir_count > 1)
                begin
                    dir_count--;
                    dir_bytes -= dir_size[dir_count];
                    n_evict++;
                end
                dir_bytes += 32'(r.entry_bytes);
            end
        end
        else if (r.op == OP_CLEAR)
        begin
            for (i = dir_count; i > 0; i--)
            begin
                if (!found && dir_key[i - 1] == r.key)
                begin
                    found = 1'b1;
                    pos = i - 1;
                end
            end
            if (found)
            begin
                dir_count--;
                dir_bytes -= dir_size[pos];
                for (i = pos; i < dir_count; i++)
                begin
                    dir_key[i] = dir_key[i + 1];
                    dir_size[i] = dir_size[i + 1];
                end
            end
        end
        else if (r.op == OP_CLEAR_ALL)
        begin
            dir_count = 0;
            dir_bytes = 0;
        end
        res.hit = found;
        res.hit_position = POS_W'(pos);
        res.evicted_count = EVC_W'(n_evict);
        res.occupancy = OCC_W'(dir_count);
        res.total_bytes = BYTES_W'(dir_bytes);
        return res;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(mtf_lookup(req));
            if (!req_valid || req_ready)
            begin
                if (pending_req.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    req <= pending_req.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response ready, with an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD - 1;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // response monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got %h", $time, rsp);
                errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("hit", 32'(want.hit), 32'(rsp.hit));
                check_field("hit_position", 32'(want.hit_position),
                            32'(rsp.hit_position));
                check_field("evicted_count", 32'(want.evicted_count),
                            32'(rsp.evicted_count));
                check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
                check_field("total_bytes", 32'(want.total_bytes), 32'(rsp.total_bytes));
                n_rsp++;
                if (want.hit)
                    n_hits++;
                if (want.evicted_count != 0)
                    n_evicting++;
                if (32'(want.occupancy) > peak_occ)
                    peak_occ = 32'(want.occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input int unsigned nbytes);
        req_t it;
        it.op = op;
        it.key = key;
        it.entry_bytes = SIZE_W'(nbytes);
        pending_req.push_back(it);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_valid)
            @(posedge clk);
    endtask

    task automatic write_budget(input logic [BUDGET_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        byte_limit = 32'(value);
        n_budgets++;
    endtask

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct <= tx_pct;
        rx_stall_pct <= rx_pct;
    endtask

    task automatic queue_random(input int unsigned count, input int unsigned pool_n,
                                input int unsigned size_max);
        req_t it;
        logic [KEY_W-1:0] base;
        int unsigned sel;
        int unsigned n;
        base = KEY_W'($urandom);
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            it.key = base + KEY_W'($urandom_range(pool_n - 1));
            if ($urandom_range(4) == 0)
                it.entry_bytes = SIZE_W'($urandom_range(MAX_ENTRY_BYTES));
            else
                it.entry_bytes = SIZE_W'($urandom_range(size_max));
            if (sel < 14)
                it.op = OP_CLEAR;
            else if (sel < 17)
                it.op = OP_CLEAR_ALL;
            else if (sel < 20)
                it.op = OP_UNUSED;
            else
            begin
                it.op = OP_ACCESS;
                if (sel < 25)
                    it.key = KEY_W'($urandom);
            end
            pending_req.push_back(it);
        end
    endtask

    initial
    begin
        logic [KEY_W-1:0] fill_base;
        req_t it;
        int unsigned n;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset budget
        push_req(OP_ACCESS, 31'h0, 0);
        push_req(OP_ACCESS, 31'h7FFFFFFF, MAX_ENTRY_BYTES);
        push_req(OP_ACCESS, 31'h0, MAX_ENTRY_BYTES);
        push_req(OP_ACCESS, 31'h2AAAAAAA, 300000);
        push_req(OP_ACCESS, 31'h55555555, 32'h55555);
        push_req(OP_ACCESS, 31'h55555555, 1);
        push_req(OP_CLEAR, 31'd12345, 0);
        push_req(OP_ACCESS, 31'd10, 1000);
        push_req(OP_ACCESS, 31'd11, 2000);
        push_req(OP_ACCESS, 31'd12, 4000);
        push_req(OP_CLEAR, 31'd11, 0);
        push_req(OP_CLEAR, 31'd12, 0);
        push_req(OP_CLEAR, 31'h55555555, 0);
        push_req(OP_UNUSED, 31'h7FFFFFFF, MAX_ENTRY_BYTES);
        push_req(OP_CLEAR_ALL, 31'h7FFFFFFF, MAX_ENTRY_BYTES);
        push_req(OP_CLEAR, 31'd10, 0);
        push_req(OP_ACCESS, 31'd10, 0);
        push_req(OP_ACCESS, 31'd20, 0);
        push_req(OP_CLEAR, 31'd10, 0);
        push_req(OP_UNUSED, 31'd0, 0);
        push_req(OP_ACCESS, 31'd1, 500000);
        push_req(OP_ACCESS, 31'd2, 0);
        push_req(OP_ACCESS, 31'd3, 1);
        push_req(OP_CLEAR_ALL, 31'd0, 0);
        wait_idle();

        // long response hold-off while requests keep coming
        write_budget(24'd1000000);
        set_idling(0, 0);
        hold_token <= hold_token + 1;
        queue_random(30, 24, 60000);
        wait_idle();

        // fill the directory to capacity with small entries
        write_budget(24'hFFFFFF);
        set_idling(0, 62);
        fill_base = KEY_W'($urandom);
        for (n = 0; n < 270; n++)
        begin
            it.op = OP_ACCESS;
            it.entry_bytes = SIZE_W'($urandom_range(20000));
            if ($urandom_range(99) < 97)
                it.key = fill_base + KEY_W'(n);
            else
                it.key = fill_base + KEY_W'($urandom_range(n));
            pending_req.push_back(it);
        end
        wait_idle();

        // hit on the tail entry, then a miss that flushes a full directory
        push_req(OP_ACCESS, dir_key[dir_count - 1], 0);
        wait_idle();
        write_budget(24'd0);
        push_req(OP_ACCESS, fill_base + KEY_W'(1000), 1);
        wait_idle();

        set_idling(62, 0);
        queue_random(30, 8, 1000);
        wait_idle();

        write_budget(24'd2000000);
        set_idling(24, 24);
        queue_random(40, 30, 200000);
        wait_idle();

        write_budget(BUDGET_W'($urandom_range(24'hFFFFFF)));
        set_idling(0, 0);
        queue_random(20, 16, 300000);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d hits, %0d with evictions, peak occupancy %0d",
                 n_rsp, n_hits, n_evicting, peak_occ);
        $display("byte budget written %0d times, %0d mismatches", n_budgets, errors);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
